@@ hdl/arxp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX plant model package
// Shared widths, types, register indexes and mode codes for the ARX step.
// ----------------------------------------------------------------------------
package arxp_pkg;

    // model orders and input delay line depth
    localparam int FB_ORDER   = 3;
    localparam int FF_ORDER   = 3;
    localparam int MAX_DELAY  = 16;
    localparam int IN_DEPTH   = MAX_DELAY + FF_ORDER;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int DELAY_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int HIST_IDX_W = $clog2(IN_DEPTH);

    // datapath widths: Q7.8 x Q1.16 products summed in Q.24
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 40;
    localparam int FRAC_SHIFT = 16;
    localparam int Y_W        = ACC_W - FRAC_SHIFT;

    // rounding bias and saturation bounds
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [Y_W-1:0]   Y_MAX = Y_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Y_W-1:0]   Y_MIN = -Y_W'(1 << (SAMPLE_W - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic [DELAY_W-1:0]         delay_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FB_COEF_1       = 3'd0,
        REG_FB_COEF_2       = 3'd1,
        REG_FB_COEF_3       = 3'd2,
        REG_FF_COEF_0       = 3'd3,
        REG_FF_COEF_1       = 3'd4,
        REG_FF_COEF_2       = 3'd5,
        REG_TRANSPORT_DELAY = 3'd6
    } cfg_idx_t;

    // request mode
    typedef enum logic {
        MODE_STEP  = 1'b0,
        MODE_CLEAR = 1'b1
    } mode_t;

    // configuration register set
    typedef struct packed {
        coef_t [FB_ORDER-1:0] fb_coef;
        coef_t [FF_ORDER-1:0] ff_coef;
        delay_t               transport_delay;
    } cfg_t;

endpackage
`default_nettype wire

@@ hdl/arxp_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX configuration registers
// Holds coefficients and transport delay; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module arxp_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [arxp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [arxp_pkg::COEF_W-1:0]    cfg_wdata,
    output arxp_pkg::cfg_t                      cfg
);

    arxp_pkg::cfg_t cfg_reg;
    arxp_pkg::cfg_t cfg_next;

    // decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (arxp_pkg::cfg_idx_t'(cfg_index))
                arxp_pkg::REG_FB_COEF_1:       cfg_next.fb_coef[0] = cfg_wdata;
                arxp_pkg::REG_FB_COEF_2:       cfg_next.fb_coef[1] = cfg_wdata;
                arxp_pkg::REG_FB_COEF_3:       cfg_next.fb_coef[2] = cfg_wdata;
                arxp_pkg::REG_FF_COEF_0:       cfg_next.ff_coef[0] = cfg_wdata;
                arxp_pkg::REG_FF_COEF_1:       cfg_next.ff_coef[1] = cfg_wdata;
                arxp_pkg::REG_FF_COEF_2:       cfg_next.ff_coef[2] = cfg_wdata;
                arxp_pkg::REG_TRANSPORT_DELAY: begin
                    cfg_next.transport_delay = cfg_wdata[arxp_pkg::DELAY_W-1:0];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // hold the register set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ hdl/arxp_delay_line.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX input delay line
// Shift register of past control samples with taps at delay, delay+1, delay+2.
// ----------------------------------------------------------------------------
module arxp_delay_line (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            shift_en,
    input  wire logic            clear,
    input  arxp_pkg::sample_t    sample,
    input  arxp_pkg::delay_t     delay,
    output arxp_pkg::sample_t    taps [arxp_pkg::FF_ORDER]
);

    arxp_pkg::sample_t                      line_reg [arxp_pkg::IN_DEPTH];
    arxp_pkg::sample_t                      line_next [arxp_pkg::IN_DEPTH];
    arxp_pkg::sample_t                      shifted [arxp_pkg::IN_DEPTH];
    logic [arxp_pkg::HIST_IDX_W-1:0]        delay_sat;

    // line as it stands once the current sample is pushed in
    always_comb begin
        shifted[0] = sample;
        for (int j = 1; j < arxp_pkg::IN_DEPTH; j++) begin
            shifted[j] = line_reg[j-1];
        end
    end

    // clamp delay to MAX_DELAY so every tap stays within the line
    assign delay_sat = (delay > arxp_pkg::DELAY_W'(arxp_pkg::MAX_DELAY))
                     ? arxp_pkg::HIST_IDX_W'(arxp_pkg::MAX_DELAY)
                     : arxp_pkg::HIST_IDX_W'(delay);

    // select feedforward taps
    always_comb begin
        for (int i = 0; i < arxp_pkg::FF_ORDER; i++) begin
            taps[i] = shifted[delay_sat + arxp_pkg::HIST_IDX_W'(i)];
        end
    end

    // advance, clear or hold
    always_comb begin
        for (int j = 0; j < arxp_pkg::IN_DEPTH; j++) begin
            if (clear) begin
                line_next[j] = '0;
            end else if (shift_en) begin
                line_next[j] = shifted[j];
            end else begin
                line_next[j] = line_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < arxp_pkg::IN_DEPTH; j++) begin
                line_reg[j] <= '0;
            end
        end else begin
            for (int j = 0; j < arxp_pkg::IN_DEPTH; j++) begin
                line_reg[j] <= line_next[j];
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/arxp_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX multiply-accumulate
// Sums feedforward products and noise, subtracts feedback products, rounds and saturates.
// ----------------------------------------------------------------------------
module arxp_mac (
    input  arxp_pkg::cfg_t       cfg,
    input  arxp_pkg::sample_t    taps [arxp_pkg::FF_ORDER],
    input  arxp_pkg::sample_t    y_hist [arxp_pkg::FB_ORDER],
    input  arxp_pkg::sample_t    noise,
    output arxp_pkg::sample_t    y,
    output logic                 sat
);

    logic signed [arxp_pkg::ACC_W-1:0]  acc;
    logic signed [arxp_pkg::ACC_W-1:0]  rounded;
    logic signed [arxp_pkg::ACC_W-1:0]  shifted;
    logic signed [arxp_pkg::PROD_W-1:0] ff_prod [arxp_pkg::FF_ORDER];
    logic signed [arxp_pkg::PROD_W-1:0] fb_prod [arxp_pkg::FB_ORDER];
    logic signed [arxp_pkg::Y_W-1:0]    y_wide;

    // products, one multiplier per coefficient
    always_comb begin
        for (int i = 0; i < arxp_pkg::FF_ORDER; i++) begin
            ff_prod[i] = $signed(cfg.ff_coef[i]) * $signed(taps[i]);
        end
        for (int j = 0; j < arxp_pkg::FB_ORDER; j++) begin
            fb_prod[j] = $signed(cfg.fb_coef[j]) * $signed(y_hist[j]);
        end
    end

    // accumulate in Q.24, round half up, drop 16 fraction bits
    always_comb begin
        acc = arxp_pkg::ACC_W'($signed(noise)) <<< arxp_pkg::FRAC_SHIFT;
        for (int i = 0; i < arxp_pkg::FF_ORDER; i++) begin
            acc = acc + arxp_pkg::ACC_W'(ff_prod[i]);
        end
        for (int j = 0; j < arxp_pkg::FB_ORDER; j++) begin
            acc = acc - arxp_pkg::ACC_W'(fb_prod[j]);
        end
        rounded = acc + arxp_pkg::ROUND_BIAS;
        shifted = rounded >>> arxp_pkg::FRAC_SHIFT;
        y_wide  = shifted[arxp_pkg::Y_W-1:0];
    end

    // clip to the sample range
    always_comb begin
        if (y_wide > arxp_pkg::Y_MAX) begin
            y   = arxp_pkg::Y_MAX[arxp_pkg::SAMPLE_W-1:0];
            sat = 1'b1;
        end else if (y_wide < arxp_pkg::Y_MIN) begin
            y   = arxp_pkg::Y_MIN[arxp_pkg::SAMPLE_W-1:0];
            sat = 1'b1;
        end else begin
            y   = y_wide[arxp_pkg::SAMPLE_W-1:0];
            sat = 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ hdl/arx_plant_model_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX plant model step
// Per MODE_STEP request, one difference-equation step: pushes the control sample
// into the input delay line and returns the new saturated plant output.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_valid/s_ready    s_mode, s_control_sample, s_noise_sample
//  m_*       out        m_valid/m_ready    m_plant_output, m_saturated
//  cfg_*     in         cfg_we             cfg_index, cfg_wdata
//
//  Via input and result registers; one request per cycle while m_ready is high.
//  The cycle time is set by the six parallel multiplies and the adder tree that
//  feeds the output history register.
//  aresetn is synchronous, active low; it clears config, both histories and
//  the valid flags.
//  A stalled result holds in the output register; the input register still
//  frees up whenever the result register moves.
// ----------------------------------------------------------------------------
module arx_plant_model_step (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_mode,
    input  wire logic signed [15:0]             s_control_sample,
    input  wire logic signed [15:0]             s_noise_sample,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [15:0]                  m_plant_output,
    output logic                                m_saturated,
    input  wire logic                           cfg_we,
    input  wire logic [arxp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [arxp_pkg::COEF_W-1:0]    cfg_wdata
);

    arxp_pkg::cfg_t      cfg;

    logic                in_valid_reg;
    arxp_pkg::mode_t     in_mode_reg;
    arxp_pkg::sample_t   in_u_reg;
    arxp_pkg::sample_t   in_noise_reg;

    logic                out_valid_reg;
    arxp_pkg::sample_t   out_y_reg;
    logic                out_sat_reg;

    arxp_pkg::sample_t   y_hist_reg [arxp_pkg::FB_ORDER];
    arxp_pkg::sample_t   taps [arxp_pkg::FF_ORDER];
    arxp_pkg::sample_t   mac_y;
    logic                mac_sat;
    logic                advance;
    logic                do_step;
    logic                do_clear;

    // move the held request into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign do_step  = advance && (in_mode_reg == arxp_pkg::MODE_STEP);
    assign do_clear = advance && (in_mode_reg == arxp_pkg::MODE_CLEAR);

    arxp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    arxp_delay_line u_delay_line (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (do_step),
        .clear    (do_clear),
        .sample   (in_u_reg),
        .delay    (cfg.transport_delay),
        .taps     (taps)
    );

    arxp_mac u_mac (
        .cfg    (cfg),
        .taps   (taps),
        .y_hist (y_hist_reg),
        .noise  (in_noise_reg),
        .y      (mac_y),
        .sat    (mac_sat)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg  <= arxp_pkg::mode_t'(s_mode);
            in_u_reg     <= s_control_sample;
            in_noise_reg <= s_noise_sample;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_clear) begin
            out_y_reg   <= '0;
            out_sat_reg <= 1'b0;
        end else if (do_step) begin
            out_y_reg   <= mac_y;
            out_sat_reg <= mac_sat;
        end
    end

    // output history, newest first
    always_ff @(posedge aclk) begin
        if (!aresetn || do_clear) begin
            for (int j = 0; j < arxp_pkg::FB_ORDER; j++) begin
                y_hist_reg[j] <= '0;
            end
        end else if (do_step) begin
            y_hist_reg[0] <= mac_y;
            for (int j = 1; j < arxp_pkg::FB_ORDER; j++) begin
                y_hist_reg[j] <= y_hist_reg[j-1];
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_plant_output = out_y_reg;
    assign m_saturated    = out_sat_reg;

endmodule
`default_nettype wire

@@ hdl/arxp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX port checker
// Watches the top-level ports for stall, saturation and reset behavior.
// ----------------------------------------------------------------------------
module arxp_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic signed [15:0]             m_plant_output,
    input wire logic                           m_saturated
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_plant_output)
                                && $stable(m_saturated))
        else $error("stalled result changed");

    // a clipped result sits on a range limit
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> (m_plant_output == 16'sh7FFF)
                                   || (m_plant_output == -16'sh8000))
        else $error("saturation flag without limit value");

    // the block only backs up while a result is waiting
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with result side free");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind arx_plant_model_step arxp_checker u_arxp_checker (.*);
`default_nettype wire
